### hw/rtl/dma_channel_pool_allocator_core_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef DMA_CHANNEL_POOL_ALLOCATOR_CORE_MACROS_SVH
`define DMA_CHANNEL_POOL_ALLOCATOR_CORE_MACROS_SVH

// Check a same-cycle implication, ignored while in reset.
`define DCPA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check an implication in the following cycle, ignored while in reset.
`define DCPA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hw/rtl/dcpa_pkg.sv
// Types, codes and helpers for the DMA channel pool allocator.
package dcpa_pkg;

  localparam int CHANNELS = 8;
  localparam int CHAN_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int BITS_W   = 6;
  localparam int PRIO_W   = 3;

  localparam logic [CHAN_W:0]  CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);
  localparam logic [BITS_W-1:0] WIDTH_8   = BITS_W'(8);
  localparam logic [BITS_W-1:0] WIDTH_16  = BITS_W'(16);
  localparam logic [BITS_W-1:0] WIDTH_32  = BITS_W'(32);
  localparam logic [PRIO_W-1:0] PRIO_MAX  = PRIO_W'(3);

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_BUSY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STATE  = 2'd1,
    ST_PARAM  = 2'd2,
    ST_NOFREE = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] count;
    logic [BITS_W-1:0]  periph_bits;
    logic [BITS_W-1:0]  mem_bits;
    logic [PRIO_W-1:0]  prio;
    logic               circular;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CHAN_W-1:0]  granted;
    logic [COUNT_W-1:0] remaining;
    logic               done_res;
  } rsp_t;

  // Request token that walks the cell chain, collecting its response.
  typedef struct packed {
    logic               vld;
    logic [2:0]         op;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] count;
    logic               circular;
    logic               param_ok;
    logic               taken;
    rsp_t               rsp;
  } tok_t;

  function automatic logic width_ok(input logic [BITS_W-1:0] w);
    return (w == WIDTH_8) || (w == WIDTH_16) || (w == WIDTH_32);
  endfunction

endpackage

### hw/rtl/dcpa_cell.sv
// One channel of the pool: holds its mode and count, acts on the passing token.
module dcpa_cell
  import dcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAN_W-1:0] cell_id,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  mode_e              mode_r, mode_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  tok_t               tok_r, tok_nxt;
  logic               hit;

  assign hit = (tok_in.channel == cell_id);

  // Apply the request to this channel and update the token
  always_comb begin
    mode_nxt = mode_r;
    left_nxt = left_r;
    tok_nxt  = tok_in;
    if (tok_in.vld) begin
      unique case (tok_in.op)
        OP_ALLOC: begin
          if (!tok_in.taken && mode_r == MODE_FREE) begin
            mode_nxt            = MODE_ALLOC;
            left_nxt            = '0;
            tok_nxt.taken       = 1'b1;
            tok_nxt.rsp.status  = ST_OK;
            tok_nxt.rsp.granted = cell_id;
          end
        end
        OP_FREE: begin
          if (hit) begin
            mode_nxt = MODE_FREE;
            left_nxt = '0;
          end
        end
        OP_START: begin
          if (hit) begin
            if (mode_r != MODE_ALLOC) begin
              tok_nxt.rsp.status = ST_STATE;
            end else if (!tok_in.param_ok) begin
              tok_nxt.rsp.status = ST_PARAM;
            end else if (tok_in.circular) begin
              mode_nxt = MODE_BUSY;
              left_nxt = tok_in.count;
            end else begin
              left_nxt             = '0;
              tok_nxt.rsp.done_res = 1'b1;
            end
          end
        end
        OP_STOP: begin
          if (hit) begin
            if (mode_r != MODE_BUSY) begin
              tok_nxt.rsp.status = ST_STATE;
            end else begin
              mode_nxt = MODE_ALLOC;
              left_nxt = '0;
            end
          end
        end
        OP_QUERY: begin
          if (hit && mode_r == MODE_BUSY) begin
            tok_nxt.rsp.remaining = left_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold channel state; pass the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FREE;
      left_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

### hw/rtl/dma_channel_pool_allocator_core.sv
// DMA channel pool allocator: a chain of CHANNELS cells, one per channel.
// The request token steps through one channel cell per cycle from input
// acceptance; the response is then registered and out_valid is raised.
// One request is in flight: a new request is accepted only after the result is taken.
// Reset (rst_n low, synchronous): every channel free with count zero, no
// transaction in flight.
module dma_channel_pool_allocator_core
  import dcpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  tok_t chain [CHANNELS+1];
  logic busy_r, busy_nxt;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r;
  logic in_acc, out_acc;
  logic in_pool;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign in_pool  = ({1'b0, in_data.channel} < CHAN_LIMIT);

  // Build the entry token with its starting status
  always_comb begin
    chain[0].vld           = in_acc;
    chain[0].op            = in_data.op;
    chain[0].channel       = in_data.channel;
    chain[0].count         = in_data.count;
    chain[0].circular      = in_data.circular;
    chain[0].param_ok      = (in_data.count != '0) && width_ok(in_data.periph_bits) &&
                             width_ok(in_data.mem_bits) && (in_data.prio <= PRIO_MAX);
    chain[0].taken         = 1'b0;
    chain[0].rsp.granted   = '0;
    chain[0].rsp.remaining = '0;
    chain[0].rsp.done_res  = 1'b0;
    unique case (in_data.op) inside
      OP_ALLOC:                               chain[0].rsp.status = ST_NOFREE;
      OP_FREE, OP_START, OP_STOP, OP_QUERY:   chain[0].rsp.status =
                                                in_pool ? ST_OK : ST_PARAM;
      default:                                chain[0].rsp.status = ST_PARAM;
    endcase
  end

  // Row of channel cells
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    dcpa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (CHAN_W'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Track the transaction in flight and the result register
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (out_acc) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (chain[CHANNELS].vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the response as the token leaves the last cell
  always_ff @(posedge clk) begin
    if (chain[CHANNELS].vld) begin
      out_data_r <= chain[CHANNELS].rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/dcpa_checker.sv
// Port-level checks for the allocator, bound to the top level.
`include "dma_channel_pool_allocator_core_macros.svh"

module dcpa_checker
  import dcpa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input req_t in_data,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // A stalled result holds its value
  `DCPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // One transaction in flight: no new request after an accept
  `DCPA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)

  // A pending result blocks new requests
  `DCPA_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)

  // Grant only on a successful alloc; done only on success
  `DCPA_ASSERT_NOW(a_rsp_fields, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.granted == '0 && !out_data.done_res)

endmodule

bind dma_channel_pool_allocator_core dcpa_checker u_dcpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
